// ===== sv/asw_pkg.sv =====
// ----------------------------------------------------------------------------
// asw_pkg
// Shared types and constants of the alive supervision watchdog.
// ----------------------------------------------------------------------------
package asw_pkg;

	// Upper bound of supervised entities; expected_counts holds one byte each
	localparam int MAX_ENTITIES = 5;
	localparam int ID_W         = 4;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 8 * MAX_ENTITIES;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 3'd5;

	// Request kinds; the fourth code is unused
	typedef enum logic [1:0] {
		K_TICK  = 2'd0,
		K_ALIVE = 2'd1,
		K_QUERY = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FAILED  = 2'd1,
		ST_EXPIRED = 2'd2,
		ST_DEACT   = 2'd3
	} status_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;   // request taken this cycle
		logic step;     // check the entity under the walk index
		logic finish;   // recompute global status after the walk
		logic load;     // load the result register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic cycle_end;    // request is a tick that closes a supervision cycle
		logic last_entity;  // walk index sits on the last entity
	} sts_t;

endpackage

// ===== sv/asw_ctrl.sv =====
// ----------------------------------------------------------------------------
// asw_ctrl
// Sequencer: accepts requests, walks the entities at a cycle end, owns the
// result valid flag.
// ----------------------------------------------------------------------------
module asw_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  asw_pkg::sts_t sts,
	output asw_pkg::cmd_t cmd
);
	import asw_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	// Hold off while walking or while the result slot stays occupied
	assign in_stall   = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign out_valid  = out_valid_q;

	assign cmd.accept = in_valid && !in_stall;
	assign cmd.step   = (state_q == S_CHECK);
	assign cmd.finish = (state_q == S_FINISH);
	assign cmd.load   = (cmd.accept && !sts.cycle_end) || cmd.finish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.accept && sts.cycle_end) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (sts.last_entity) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			out_valid_q <= cmd.load || (out_valid_q && out_stall);
		end
	end

endmodule

// ===== sv/asw_datapath.sv =====
// ----------------------------------------------------------------------------
// asw_datapath
// Configuration, per-entity counters and status, cycle check unit and the
// result register.
// ----------------------------------------------------------------------------
module asw_datapath #(
	parameter int ENTITIES = 5
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write_en,
	input  logic [asw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [asw_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic [1:0]                     kind,
	input  logic [asw_pkg::ID_W-1:0]       entity_id,
	input  asw_pkg::cmd_t                  cmd,
	output asw_pkg::sts_t                  sts,
	output logic                           accepted,
	output logic [1:0]                     local_status,
	output logic [1:0]                     global_status,
	output logic                           expired_flag
);
	import asw_pkg::*;

	localparam int              IDX_W    = (ENTITIES > 1) ? $clog2(ENTITIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTITIES - 1);
	localparam logic [ID_W-1:0]  MAX_ID   = ID_W'(ENTITIES);

	// Configuration
	logic [MAX_ENTITIES-1:0][7:0] exp_q;
	logic [7:0]                   lower_q;
	logic [7:0]                   upper_q;
	logic [7:0]                   limit_q;
	logic [15:0]                  period_q;
	logic                         en_q;

	// Supervision state
	logic [15:0] cnt_q  [ENTITIES];
	logic [7:0]  fcyc_q [ENTITIES];
	status_t     stat_q [ENTITIES];
	logic [15:0] tick_q;
	status_t     overall_q;
	logic        sticky_q;
	logic [IDX_W-1:0] idx_q;

	logic             id_ok;
	logic [IDX_W-1:0] rd_idx;
	logic [15:0]      cur_cnt;
	logic [7:0]       cur_fc;
	status_t          cur_stat;
	logic [7:0]       expect_b;
	logic [15:0]      tick_nxt;
	logic             tick_en;
	logic             fail;
	logic [7:0]       fc_inc;
	logic             any_exp;
	logic             any_fail;
	status_t          g_next;
	logic             acc_d;
	status_t          loc_d;
	status_t          glob_d;
	logic             flag_d;

	assign id_ok    = (entity_id != '0) && (entity_id <= MAX_ID);
	assign rd_idx   = cmd.step ? idx_q : IDX_W'(entity_id - ID_W'(1));
	assign cur_cnt  = cnt_q[rd_idx];
	assign cur_fc   = fcyc_q[rd_idx];
	assign cur_stat = stat_q[rd_idx];
	assign expect_b = exp_q[rd_idx];

	assign tick_nxt = tick_q + 16'd1;
	assign tick_en  = (kind == K_TICK) && en_q;

	assign sts.cycle_end   = tick_en && (tick_nxt >= period_q);
	assign sts.last_entity = (idx_q == LAST_IDX);

	// Count outside [expected - lower, expected + upper]
	assign fail = (({1'b0, cur_cnt} + {9'd0, lower_q}) < {9'd0, expect_b}) ||
	              ({1'b0, cur_cnt} > ({9'd0, expect_b} + {9'd0, upper_q}));
	assign fc_inc = (cur_fc == 8'hFF) ? cur_fc : cur_fc + 8'd1;

	always_comb begin
		any_exp  = 1'b0;
		any_fail = 1'b0;
		for (int i = 0; i < ENTITIES; i++) begin
			any_exp  = any_exp  || (stat_q[i] == ST_EXPIRED);
			any_fail = any_fail || (stat_q[i] == ST_FAILED);
		end
		if (any_exp) begin
			g_next = ST_EXPIRED;
		end else if (any_fail) begin
			g_next = ST_FAILED;
		end else begin
			g_next = ST_OK;
		end
	end

	always_comb begin
		acc_d  = 1'b0;
		loc_d  = ST_OK;
		glob_d = overall_q;
		flag_d = sticky_q;
		if (cmd.finish || tick_en) begin
			glob_d = g_next;
			flag_d = sticky_q || any_exp;
		end
		if (cmd.finish) begin
			acc_d = 1'b1;
		end else begin
			unique case (kind)
				K_TICK: begin
					acc_d = 1'b1;
				end
				K_ALIVE, K_QUERY: begin
					if (id_ok) begin
						acc_d = 1'b1;
						loc_d = cur_stat;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q     <= {MAX_ENTITIES{8'd10}};
			lower_q   <= 8'd1;
			upper_q   <= 8'd1;
			limit_q   <= 8'd3;
			period_q  <= 16'd10;
			en_q      <= 1'b1;
			tick_q    <= '0;
			overall_q <= ST_OK;
			sticky_q  <= 1'b0;
			idx_q     <= '0;
			for (int i = 0; i < ENTITIES; i++) begin
				cnt_q[i]  <= '0;
				fcyc_q[i] <= '0;
				stat_q[i] <= ST_OK;
			end
		end else begin
			if (cfg_write_en) begin
				unique case (cfg_index)
					REG_EXPECTED: exp_q    <= cfg_wdata;
					REG_LOWER:    lower_q  <= cfg_wdata[7:0];
					REG_UPPER:    upper_q  <= cfg_wdata[7:0];
					REG_LIMIT:    limit_q  <= cfg_wdata[7:0];
					REG_PERIOD:   period_q <= cfg_wdata[15:0];
					REG_ENABLE: begin
						en_q <= cfg_wdata[0];
						if (!cfg_wdata[0]) begin
							overall_q <= ST_DEACT;
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.accept) begin
				idx_q <= '0;
				if (tick_en) begin
					tick_q    <= sts.cycle_end ? 16'd0 : tick_nxt;
					overall_q <= g_next;
					sticky_q  <= sticky_q || any_exp;
				end
				if ((kind == K_ALIVE) && id_ok && (cur_cnt != 16'hFFFF)) begin
					cnt_q[rd_idx] <= cur_cnt + 16'd1;
				end
			end
			if (cmd.step) begin
				idx_q         <= idx_q + IDX_W'(1);
				cnt_q[rd_idx] <= '0;
				if (fail) begin
					fcyc_q[rd_idx] <= fc_inc;
					stat_q[rd_idx] <= (fc_inc >= limit_q) ? ST_EXPIRED : ST_FAILED;
				end else begin
					fcyc_q[rd_idx] <= '0;
					stat_q[rd_idx] <= ST_OK;
				end
			end
			if (cmd.finish) begin
				overall_q <= g_next;
				sticky_q  <= sticky_q || any_exp;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			accepted      <= acc_d;
			local_status  <= loc_d;
			global_status <= glob_d;
			expired_flag  <= flag_d;
		end
	end

endmodule

// ===== sv/alive_supervision_watchdog_unit.sv =====
// ----------------------------------------------------------------------------
// alive_supervision_watchdog_unit
// Alive supervision of up to five entities with a periodic check.
// ----------------------------------------------------------------------------
//
//  channel  handshake              payload
//  -------  ---------------------  ------------------------------------------
//  in       in_valid / in_stall    kind, entity_id
//  out      out_valid / out_stall  accepted, local_status, global_status,
//                                  expired_flag
//  cfg      cfg_write_en           cfg_index, cfg_wdata (no read-back)
//
//  Indications, queries, disabled ticks and ticks inside a cycle load the
//  result register at the edge the request is taken.
//  A tick that closes a supervision cycle loads no result itself: the
//  shared check unit walks one entity per cycle, then global status is
//  recomputed from the registered entity states and the result loads.
//  Reset loads the register defaults and clears all counters and states in
//  flip-flops at once; no clearing pass.
//  A stalled result holds; a new request is taken once the slot drains.
//
module alive_supervision_watchdog_unit #(
	parameter int ENTITIES = 5
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write_en,
	input  logic [asw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [asw_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     kind,
	input  logic [asw_pkg::ID_W-1:0]       entity_id,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           accepted,
	output logic [1:0]                     local_status,
	output logic [1:0]                     global_status,
	output logic                           expired_flag
);
	import asw_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequencer: accept, walk, finish
	asw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Counters, check unit and result register
	asw_datapath #(
		.ENTITIES (ENTITIES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.kind          (kind),
		.entity_id     (entity_id),
		.cmd           (cmd),
		.sts           (sts),
		.accepted      (accepted),
		.local_status  (local_status),
		.global_status (global_status),
		.expired_flag  (expired_flag)
	);

	// A cycle-closing tick must block the next request while the walk runs
	a_walk_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && sts.cycle_end |=> in_stall)
		else $error("request taken during entity walk");

	// Expired global status always comes with the sticky flag
	a_expired_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (global_status == ST_EXPIRED) |-> expired_flag)
		else $error("expired status without sticky flag");

	// A local status other than ok only on an accepted request
	a_local_accept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (local_status != ST_OK) |-> accepted)
		else $error("local status on rejected request");

	// No result is loaded without a request or a finished walk
	a_load_source: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> cmd.accept || cmd.finish)
		else $error("result loaded without a source");

endmodule

// ===== bench/asw_status_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// asw_status_checker
// Watches the request, result and register ports of the alive supervision
// watchdog, keeps its own copy of the supervision state and compares every
// result with the status it expects, oldest first.
// ----------------------------------------------------------------------------
module asw_status_checker #(
	parameter int ENTITIES = 5
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write_en,
	input  logic [asw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [asw_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [1:0]                     kind,
	input  logic [asw_pkg::ID_W-1:0]       entity_id,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic                           accepted,
	input  logic [1:0]                     local_status,
	input  logic [1:0]                     global_status,
	input  logic                           expired_flag,
	output int                             mismatches,
	output int                             outstanding
);
	import asw_pkg::*;

	typedef struct packed {
		logic    accepted;
		status_t local_st;
		status_t global_st;
		logic    expired;
	} status_word_t;

	// Register copies
	logic [CFG_DATA_W-1:0] want_counts;
	logic [7:0]            lower_margin;
	logic [7:0]            upper_margin;
	logic [7:0]            fail_limit;
	logic [15:0]           period;
	logic                  enabled;

	// Supervision state
	logic [15:0] alive_cnt   [ENTITIES];
	logic [7:0]  fail_cycles [ENTITIES];
	status_t     ent_status  [ENTITIES];
	logic [15:0] tick_cnt;
	status_t     overall;
	logic        expired_seen;

	status_word_t due_status_q[$];
	int           errors;

	// Grade every entity at the end of a supervision cycle, then restart counts
	function automatic void close_cycle();
		int   have;
		int   want;
		logic short_fall;
		logic excess;
		for (int e = 0; e < ENTITIES; e++) begin
			have       = int'(alive_cnt[e]);
			want       = int'(want_counts[8*e +: 8]);
			short_fall = (have + int'(lower_margin)) < want;
			excess     = have > (want + int'(upper_margin));
			if (short_fall || excess) begin
				if (fail_cycles[e] != 8'hFF)
					fail_cycles[e] = fail_cycles[e] + 8'd1;
				ent_status[e] = (fail_cycles[e] >= fail_limit) ? ST_EXPIRED : ST_FAILED;
			end else begin
				fail_cycles[e] = '0;
				ent_status[e]  = ST_OK;
			end
			alive_cnt[e] = '0;
		end
	endfunction

	function automatic void regrade_overall();
		logic any_failed;
		logic any_expired;
		any_failed  = 1'b0;
		any_expired = 1'b0;
		for (int e = 0; e < ENTITIES; e++) begin
			if (ent_status[e] == ST_FAILED)
				any_failed = 1'b1;
			if (ent_status[e] == ST_EXPIRED)
				any_expired = 1'b1;
		end
		if (any_expired) begin
			overall      = ST_EXPIRED;
			expired_seen = 1'b1;
		end else if (any_failed) begin
			overall = ST_FAILED;
		end else begin
			overall = ST_OK;
		end
	endfunction

	// Apply one request and return the status word it should produce
	function automatic status_word_t serve_request(input logic [1:0] req_kind,
			input logic [ID_W-1:0] id);
		status_word_t ans;
		logic         known;
		int           slot;
		logic [15:0]  next_tick;
		known        = (id >= 1) && (id <= ENTITIES);
		slot         = known ? int'(id) - 1 : 0;
		ans.accepted = 1'b0;
		ans.local_st = ST_OK;
		case (req_kind)
			K_TICK: begin
				ans.accepted = 1'b1;
				if (enabled) begin
					next_tick = tick_cnt + 16'd1;
					if (next_tick >= period) begin
						tick_cnt = '0;
						close_cycle();
					end else begin
						tick_cnt = next_tick;
					end
					regrade_overall();
				end
			end
			K_ALIVE: begin
				if (known) begin
					ans.accepted = 1'b1;
					if (alive_cnt[slot] != 16'hFFFF)
						alive_cnt[slot] = alive_cnt[slot] + 16'd1;
					ans.local_st = ent_status[slot];
				end
			end
			K_QUERY: begin
				if (known) begin
					ans.accepted = 1'b1;
					ans.local_st = ent_status[slot];
				end
			end
			default: ;
		endcase
		ans.global_st = overall;
		ans.expired   = expired_seen;
		return ans;
	endfunction

	function automatic void compare_field(input string field, input logic [1:0] want,
			input logic [1:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		status_word_t seen;
		status_word_t due;
		if (!arst_n) begin
			want_counts  = 40'h0A0A0A0A0A;
			lower_margin = 8'd1;
			upper_margin = 8'd1;
			fail_limit   = 8'd3;
			period       = 16'd10;
			enabled      = 1'b1;
			for (int e = 0; e < ENTITIES; e++) begin
				alive_cnt[e]   = '0;
				fail_cycles[e] = '0;
				ent_status[e]  = ST_OK;
			end
			tick_cnt     = '0;
			overall      = ST_OK;
			expired_seen = 1'b0;
			due_status_q.delete();
			errors       = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			// Results first: a result never leaves at the edge its request enters
			if (out_valid && !out_stall) begin
				seen = {accepted, local_status, global_status, expired_flag};
				if (due_status_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, accepted %0d local %0d global %0d flag %0d",
						$time, accepted, local_status, global_status, expired_flag);
				end else begin
					due = due_status_q.pop_front();
					compare_field("accepted", {1'b0, due.accepted}, {1'b0, seen.accepted});
					compare_field("local_status", due.local_st, seen.local_st);
					compare_field("global_status", due.global_st, seen.global_st);
					compare_field("expired_flag", {1'b0, due.expired}, {1'b0, seen.expired});
				end
			end
			if (cfg_write_en) begin
				case (cfg_index)
					REG_EXPECTED: want_counts  = cfg_wdata;
					REG_LOWER:    lower_margin = cfg_wdata[7:0];
					REG_UPPER:    upper_margin = cfg_wdata[7:0];
					REG_LIMIT:    fail_limit   = cfg_wdata[7:0];
					REG_PERIOD:   period       = cfg_wdata[15:0];
					REG_ENABLE: begin
						enabled = cfg_wdata[0];
						if (!cfg_wdata[0])
							overall = ST_DEACT;
					end
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				due_status_q.push_back(serve_request(kind, entity_id));
			outstanding <= due_status_q.size();
			mismatches  <= errors;
		end
	end

endmodule

// ===== bench/tb_alive_supervision_watchdog_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_alive_supervision_watchdog_unit
// Drives ticks, alive indications and status queries into the watchdog,
// reprograms its registers between phases and lets the status checker judge
// every result; prints the verdict at the end.
// ----------------------------------------------------------------------------
module tb_alive_supervision_watchdog_unit;
	import asw_pkg::*;

	localparam int ENTITIES     = 5;
	localparam int LONG_HOLD    = 60;            // receiver hold-off, in cycles
	localparam int SETTLE       = ENTITIES + 4;  // longer than the slowest request
	localparam int RANDOM_ITEMS = 160;
	localparam int PHASES       = 8;
	localparam logic [1:0] K_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]      req_kind;
		logic [ID_W-1:0] req_id;
	} request_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_write_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = REG_EXPECTED;
	logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
	logic                  in_valid     = 1'b0;
	logic                  in_stall;
	logic [1:0]            kind         = K_TICK;
	logic [ID_W-1:0]       entity_id    = '0;
	logic                  out_valid;
	logic                  out_stall    = 1'b0;
	logic                  accepted;
	logic [1:0]            local_status;
	logic [1:0]            global_status;
	logic                  expired_flag;
	int                    mismatches;
	int                    outstanding;

	// Idling odds in percent, set per phase
	int idle_pct  = 0;
	int stall_pct = 0;

	// Long hold-off: the stimulus bumps the token, the receiver counts it out
	int hold_token = 0;
	int hold_seen  = 0;
	int hold_left  = 0;

	// What was last programmed, used only to shape the requests
	logic [CFG_DATA_W-1:0] sh_counts = 40'h0A0A0A0A0A;
	logic [7:0]            sh_lower  = 8'd1;
	logic [7:0]            sh_upper  = 8'd1;
	logic [15:0]           sh_period = 16'd10;
	logic                  sh_enable = 1'b1;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	alive_supervision_watchdog_unit #(.ENTITIES(ENTITIES)) dut (.*);

	asw_status_checker #(.ENTITIES(ENTITIES)) status_checker (.*);

	// Receiver: random stalls, or a long hold-off whenever one is asked for
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_token) begin
			hold_seen <= hold_token;
			hold_left <= LONG_HOLD - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Offer one request, idling first at random; hold it until taken
	task automatic send_request(input logic [1:0] req_kind, input logic [ID_W-1:0] id);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		kind      <= req_kind;
		entity_id <= id;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_repeated(input logic [1:0] req_kind, input logic [ID_W-1:0] id,
			input int count);
		for (int i = 0; i < count; i++)
			send_request(req_kind, id);
	endtask

	// Drop valid and wait until every expected result has come back
	task automatic quiesce();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_wdata    <= value;
		@(posedge clk);
	endtask

	// Reprogram every register once the block has gone quiet
	task automatic program_regs(input logic [CFG_DATA_W-1:0] counts, input logic [7:0] lower,
			input logic [7:0] upper, input logic [7:0] limit, input logic [15:0] ticks,
			input logic enable);
		quiesce();
		set_reg(REG_EXPECTED, counts);
		set_reg(REG_LOWER, CFG_DATA_W'(lower));
		set_reg(REG_UPPER, CFG_DATA_W'(upper));
		set_reg(REG_LIMIT, CFG_DATA_W'(limit));
		set_reg(REG_PERIOD, CFG_DATA_W'(ticks));
		set_reg(REG_ENABLE, CFG_DATA_W'(enable));
		cfg_write_en <= 1'b0;
		sh_counts = counts;
		sh_lower  = lower;
		sh_upper  = upper;
		sh_period = ticks;
		sh_enable = enable;
	endtask

	// One supervision cycle: per entity an indication count near, inside or
	// just outside its window, some queries and a little noise, shuffled among
	// the cycle's ticks; the closing tick goes last.
	task automatic run_cycle(inout int counted);
		request_t plan[$];
		request_t req;
		int       want;
		int       target;
		int       ticks;
		int       j;
		for (int e = 0; e < ENTITIES; e++) begin
			want = int'(sh_counts[8*e +: 8]);
			case ($urandom_range(9))
				0, 1:    target = want - int'(sh_lower) - int'($urandom_range(1, 2));
				2, 3:    target = want + int'(sh_upper) + int'($urandom_range(1, 2));
				default: target = want - int'(sh_lower) +
						int'($urandom_range(0, int'(sh_lower) + int'(sh_upper)));
			endcase
			if (target < 0)
				target = 0;
			if (target > 12)
				target = 12;
			req.req_kind = K_ALIVE;
			req.req_id   = ID_W'(e + 1);
			repeat (target) plan.push_back(req);
		end
		repeat ($urandom_range(1, 3)) begin
			req.req_kind = K_QUERY;
			req.req_id   = ID_W'($urandom_range(1, ENTITIES));
			plan.push_back(req);
		end
		// Noise: bad ids and the unused kind
		repeat ($urandom_range(0, 2)) begin
			req.req_kind = 2'($urandom_range(1, 3));
			if (req.req_kind == K_UNUSED)
				req.req_id = ID_W'($urandom_range(15));
			else
				req.req_id = ($urandom_range(1) != 0) ? '0 :
						ID_W'($urandom_range(ENTITIES + 1, 15));
			plan.push_back(req);
		end
		ticks = (sh_period == 16'd0) ? 1 : int'(sh_period);
		req.req_kind = K_TICK;
		repeat (ticks - 1) begin
			req.req_id = ID_W'($urandom_range(15));
			plan.push_back(req);
		end
		for (int i = plan.size() - 1; i > 0; i--) begin
			j       = $urandom_range(i);
			req     = plan[i];
			plan[i] = plan[j];
			plan[j] = req;
		end
		req.req_id = ID_W'($urandom_range(15));
		plan.push_back(req);
		foreach (plan[i]) begin
			send_request(plan[i].req_kind, plan[i].req_id);
			if ((plan[i].req_kind == K_TICK && sh_enable) ||
					((plan[i].req_kind == K_ALIVE || plan[i].req_kind == K_QUERY) &&
					plan[i].req_id >= 1 && plan[i].req_id <= ENTITIES))
				counted++;
		end
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] rand_counts;
		int                    counted;
		int                    rounds;

		// Hold reset at the start, then release it once and for all
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests on the reset settings: tick ids are ignored,
		// indications and queries reject id 0 and ids above the last entity
		send_request(K_TICK, ID_W'(0));
		send_request(K_TICK, ID_W'(15));
		send_request(K_ALIVE, ID_W'(1));
		send_request(K_ALIVE, ID_W'(ENTITIES));
		send_request(K_ALIVE, ID_W'(0));
		send_request(K_ALIVE, ID_W'(ENTITIES + 1));
		send_request(K_ALIVE, ID_W'(15));
		send_request(K_QUERY, ID_W'(1));
		send_request(K_QUERY, ID_W'(ENTITIES));
		send_request(K_QUERY, ID_W'(0));
		send_request(K_QUERY, ID_W'(15));
		send_request(K_UNUSED, ID_W'(3));
		send_request(K_UNUSED, ID_W'(0));
		send_request(K_ALIVE, ID_W'(2));
		send_request(K_QUERY, ID_W'(2));
		// Close the first cycle with everyone short of indications
		send_repeated(K_TICK, ID_W'(7), 8);
		send_request(K_QUERY, ID_W'(3));
		send_request(K_ALIVE, ID_W'(4));

		// Zero failure limit: the first failed check expires, sticky flag rises
		program_regs(40'h0A0A0A0A0A, 8'd1, 8'd1, 8'd0, 16'd1, 1'b1);
		send_request(K_TICK, ID_W'(0));
		send_request(K_QUERY, ID_W'(1));

		// Supervision off: ticks ignored, indications and queries still served
		program_regs(40'h0A0A0A0A0A, 8'd1, 8'd1, 8'd3, 16'd0, 1'b0);
		send_request(K_TICK, ID_W'(0));
		send_request(K_ALIVE, ID_W'(1));
		send_request(K_QUERY, ID_W'(1));
		send_request(K_QUERY, ID_W'(0));
		// Back on: deactivated holds until the next tick; zero period ends a
		// cycle on every tick
		program_regs(40'h0A0A0A0A0A, 8'd1, 8'd1, 8'd3, 16'd0, 1'b1);
		send_request(K_QUERY, ID_W'(2));
		send_repeated(K_ALIVE, ID_W'(1), 10);
		send_request(K_TICK, ID_W'(0));
		send_request(K_TICK, ID_W'(0));

		// Period lowered below the running tick count
		program_regs(40'h0A0A0A0A0A, 8'd1, 8'd1, 8'd3, 16'd20, 1'b1);
		send_repeated(K_TICK, ID_W'(1), 6);
		program_regs(40'h0A0A0A0A0A, 8'd1, 8'd1, 8'd3, 16'd3, 1'b1);
		send_request(K_TICK, ID_W'(1));
		send_request(K_QUERY, ID_W'(1));

		// Failed-cycle count up to and past its ceiling, with the top limit
		program_regs(40'h0A0A0A0A0A, 8'd1, 8'd1, 8'd255, 16'd1, 1'b1);
		send_repeated(K_TICK, ID_W'(0), 260);
		send_request(K_QUERY, ID_W'(5));

		// Random phases, each with its own idling and register settings
		for (int p = 0; p < PHASES; p++) begin
			if (p == 2) begin
				program_regs('1, 8'd255, 8'd255, 8'd255, 16'd2, 1'b1);
			end else if (p == 5) begin
				program_regs('0, 8'd0, 8'd0, 8'd1, 16'd1, 1'b1);
			end else begin
				for (int e = 0; e < ENTITIES; e++)
					rand_counts[8*e +: 8] = 8'($urandom_range(5));
				program_regs(rand_counts, 8'($urandom_range(2)), 8'($urandom_range(2)),
					8'($urandom_range(1, 4)), 16'($urandom_range(4)), p != 6);
			end
			case (p % 4)
				0: begin
					idle_pct  <= 0;
					stall_pct <= 0;
					// Hold the results back while requests keep coming
					hold_token <= hold_token + 1;
				end
				1: begin
					idle_pct  <= 77;
					stall_pct <= 0;
				end
				2: begin
					idle_pct  <= 0;
					stall_pct <= 77;
				end
				default: begin
					idle_pct  <= 22;
					stall_pct <= 22;
				end
			endcase
			counted = 0;
			rounds  = 0;
			while (counted < RANDOM_ITEMS / PHASES) begin
				run_cycle(counted);
				rounds++;
				// Switch supervision back on halfway through the disabled phase
				if (!sh_enable && counted >= RANDOM_ITEMS / (2 * PHASES))
					program_regs(sh_counts, sh_lower, sh_upper, 8'($urandom_range(1, 4)),
						sh_period, 1'b1);
				// Pause the sender now and then until all results are back
				if (rounds % 3 == 0)
					quiesce();
			end
		end

		quiesce();
		if (mismatches == 0 && outstanding == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Watchdog on the run itself: far beyond the slowest correct run
	initial begin
		#12_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
